/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file of the block allocator.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset
`define BBA_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the default clk_i / rst_ni pair
`define BBA_ASSERT(lbl, prop, msg) \
  `BBA_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* hw/rtl/bba_pkg.sv */
// Package for the bitmap block allocator: default sizes, status codes and
// sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  // Default sizing
  localparam int NUM_BLOCKS_DEF      = 65536;
  localparam int RESERVED_BLOCKS_DEF = 66;
  localparam int WORD_BITS_DEF       = 64;

  // Transfer field widths
  localparam int IDX_W    = 16;
  localparam int STATUS_W = 2;

  // Summary rows and the shared find-first-zero unit are 64 bits wide
  localparam int SUM_BITS   = 64;
  localparam int SUM_SHIFT  = 6;
  localparam int FIND_W     = 64;
  localparam int FIND_POS_W = 6;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_ZERO = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    BBA_CLEAR,
    BBA_IDLE,
    BBA_TOP,
    BBA_SUM,
    BBA_MAP,
    BBA_DIV,
    BBA_FRD,
    BBA_FWR,
    BBA_RESP
  } bba_state_e;

endpackage

`default_nettype wire

/* hw/rtl/bba_ffz.sv */
// Shared find-first-zero unit: lowest clear bit of a 64-bit word.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_ffz import bba_pkg::*; (
  input  logic [FIND_W-1:0]     word_i,
  output logic                  found_o,
  output logic [FIND_POS_W-1:0] pos_o
);

  // Scan from the top so the lowest clear bit wins
  always_comb begin
    found_o = ~&word_i;
    pos_o   = '0;
    for (int i = FIND_W - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        pos_o = FIND_POS_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bba_ram.sv */
// Simple dual-port RAM: one write and one registered read per cycle.
// Depends on bba_pkg for nothing but house conventions; standalone.
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  parameter int AW    = 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/bitmap_block_allocator_top.sv */
// Bitmap first-fit block allocator, top level: sequencer, map and summary
// memories. Depends on bba_pkg, bba_ram and bba_ffz.
//
// Keeps one in-use bit per block in a map memory of WORD_BITS-bit words, a
// summary memory with one "word full" bit per map word (64 per row) and a
// top memory with one "row full" bit per summary row. After reset a clearing
// pass writes every map word once and marks the lowest RESERVED_BLOCKS
// blocks used; no request is taken until it ends. An allocate request walks
// top, summary and map word through one shared find-first-zero unit, one
// memory read per level, and moves on to the next 4096-word top chunk while
// the one scanned is full. A free request splits the index into word and
// bit by a reciprocal multiply; a free of block 0 or of an index beyond the
// map answers in the cycle after it is taken. One request is handled at a
// time; the next is taken once the result transfer is done.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator_top import bba_pkg::*; #(
  parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF,
  parameter int WORD_BITS       = WORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IDX_W-1:0]    s_axis_tdata,   // [15:0] block_index
  input  logic [0:0]          s_axis_tuser,   // [0] action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [IDX_W-1:0]    m_axis_tdata,   // [15:0] granted_index
  output logic [STATUS_W-1:0] m_axis_tuser    // [1:0] status
);

  // Derived sizes
  localparam int RES_EFF    = (RESERVED_BLOCKS < NUM_BLOCKS) ? RESERVED_BLOCKS : NUM_BLOCKS;
  localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int SUM_ROWS   = (MAP_WORDS + SUM_BITS - 1) / SUM_BITS;
  localparam int TOP_CHUNKS = (SUM_ROWS + SUM_BITS - 1) / SUM_BITS;
  localparam int FW_LO      = (RES_EFF == NUM_BLOCKS) ? MAP_WORDS : RES_EFF / WORD_BITS;
  localparam int AW_M       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int AW_S       = (SUM_ROWS > 1) ? $clog2(SUM_ROWS) : 1;
  localparam int AW_T       = (TOP_CHUNKS > 1) ? $clog2(TOP_CHUNKS) : 1;
  localparam int RW         = AW_T + SUM_SHIFT;
  localparam int WW         = RW + SUM_SHIFT;

  // Reciprocal divide by WORD_BITS, exact for any 16-bit index
  localparam int DIV_SHIFT = 23;
  localparam int DIV_MUL   = (2 ** DIV_SHIFT + WORD_BITS - 1) / WORD_BITS;
  localparam int DIV_MUL_W = 21;
  localparam int PROD_W    = IDX_W + DIV_MUL_W;

  // Reset contents of one map word: reserved and out-of-range bits set
  function automatic logic [WORD_BITS-1:0] init_map(input logic [AW_M-1:0] w);
    logic [WORD_BITS-1:0] v;
    logic [31:0]          base;
    logic [31:0]          pos;
    base = 32'(w) * 32'(WORD_BITS);
    for (int b = 0; b < WORD_BITS; b++) begin
      pos  = base + 32'(b);
      v[b] = (pos < 32'(RES_EFF)) || (pos >= 32'(NUM_BLOCKS));
    end
    return v;
  endfunction

  // Reset contents of one summary row: one bit per full map word
  function automatic logic [SUM_BITS-1:0] init_sum(input logic [AW_M-1:0] r);
    logic [SUM_BITS-1:0] v;
    logic [31:0]         w;
    for (int j = 0; j < SUM_BITS; j++) begin
      w    = 32'(r) * 32'(SUM_BITS) + 32'(j);
      v[j] = (w < 32'(FW_LO)) || (w >= 32'(MAP_WORDS));
    end
    return v;
  endfunction

  // Reset contents of one top chunk: one bit per full summary row
  function automatic logic [SUM_BITS-1:0] init_top(input logic [AW_M-1:0] c);
    logic [SUM_BITS-1:0] v;
    logic [31:0]         lo;
    for (int j = 0; j < SUM_BITS; j++) begin
      lo   = (32'(c) * 32'(SUM_BITS) + 32'(j)) * 32'(SUM_BITS);
      v[j] = (lo + 32'(SUM_BITS) <= 32'(FW_LO)) || (lo >= 32'(MAP_WORDS)) ||
             (FW_LO >= MAP_WORDS);
    end
    return v;
  endfunction

  // Control and payload registers
  bba_state_e           state_q, state_d;
  logic [AW_M-1:0]      sweep_q, sweep_d;
  logic [AW_T-1:0]      chunk_q, chunk_d;
  logic [RW-1:0]        row_q, row_d;
  logic [WW-1:0]        word_q, word_d;
  logic [FIND_POS_W-1:0] bit_q, bit_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [SUM_BITS-1:0]  top_word_q, top_word_d;
  logic [SUM_BITS-1:0]  sum_word_q, sum_word_d;
  logic [IDX_W-1:0]     granted_q, granted_d;
  status_e              status_q, status_d;

  // Memory ports
  logic                 map_we, sum_we, top_we;
  logic [AW_M-1:0]      map_waddr, map_raddr;
  logic [AW_S-1:0]      sum_waddr, sum_raddr;
  logic [AW_T-1:0]      top_waddr, top_raddr;
  logic [WORD_BITS-1:0] map_wdata, map_rdata;
  logic [SUM_BITS-1:0]  sum_wdata, sum_rdata;
  logic [SUM_BITS-1:0]  top_wdata, top_rdata;

  // Shared unit
  logic [FIND_W-1:0]     ffz_word;
  logic                  ffz_found;
  logic [FIND_POS_W-1:0] ffz_pos;

  // Helpers
  logic [FIND_W-1:0]    map_pad;
  logic [WORD_BITS-1:0] map_set;
  logic [WORD_BITS-1:0] map_clr;
  logic [SUM_BITS-1:0]  sum_set;
  logic [RW-1:0]        free_row;
  logic [PROD_W-1:0]    div_prod;
  logic [31:0]          bit_calc;
  logic [31:0]          grant_calc;
  logic                 in_xfer;

  bba_ram #(.DEPTH(MAP_WORDS), .WIDTH(WORD_BITS), .AW(AW_M)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  bba_ram #(.DEPTH(SUM_ROWS), .WIDTH(SUM_BITS), .AW(AW_S)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  bba_ram #(.DEPTH(TOP_CHUNKS), .WIDTH(SUM_BITS), .AW(AW_T)) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (top_we),
    .waddr_i (top_waddr),
    .wdata_i (top_wdata),
    .raddr_i (top_raddr),
    .rdata_o (top_rdata)
  );

  bba_ffz u_ffz (
    .word_i  (ffz_word),
    .found_o (ffz_found),
    .pos_o   (ffz_pos)
  );

  // Pad the map word with used bits up to the unit width
  always_comb begin
    map_pad                = '1;
    map_pad[WORD_BITS-1:0] = map_rdata;
  end

  // Feed the shared unit from the level being scanned
  always_comb begin
    case (state_q)
      BBA_TOP: ffz_word = top_rdata;
      BBA_SUM: ffz_word = sum_rdata;
      default: ffz_word = map_pad;
    endcase
  end

  assign map_set    = map_rdata | (WORD_BITS'(1) << ffz_pos);
  assign map_clr    = map_rdata & ~(WORD_BITS'(1) << bit_q);
  assign sum_set    = sum_word_q | (SUM_BITS'(1) << word_q[SUM_SHIFT-1:0]);
  assign free_row   = word_q[WW-1:SUM_SHIFT];
  assign div_prod   = PROD_W'(idx_q) * PROD_W'(DIV_MUL);
  assign bit_calc   = 32'(idx_q) - 32'(word_q) * 32'(WORD_BITS);
  assign grant_calc = 32'(word_q) * 32'(WORD_BITS) + 32'(ffz_pos);
  assign in_xfer    = s_axis_tvalid && s_axis_tready;

  // Sequencer: next state, memory accesses and result
  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    chunk_d    = chunk_q;
    row_d      = row_q;
    word_d     = word_q;
    bit_d      = bit_q;
    idx_d      = idx_q;
    top_word_d = top_word_q;
    sum_word_d = sum_word_q;
    granted_d  = granted_q;
    status_d   = status_q;

    map_we    = 1'b0;
    sum_we    = 1'b0;
    top_we    = 1'b0;
    map_waddr = word_q[AW_M-1:0];
    sum_waddr = row_q[AW_S-1:0];
    top_waddr = row_q[RW-1:SUM_SHIFT];
    map_wdata = map_set;
    sum_wdata = sum_set;
    top_wdata = top_word_q | (SUM_BITS'(1) << row_q[SUM_SHIFT-1:0]);
    map_raddr = word_q[AW_M-1:0];
    sum_raddr = row_q[AW_S-1:0];
    top_raddr = '0;

    case (state_q)
      // Sweep the reset contents into all three memories
      BBA_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = sweep_q;
        map_wdata = init_map(sweep_q);
        sum_we    = (32'(sweep_q) < 32'(SUM_ROWS));
        sum_waddr = sweep_q[AW_S-1:0];
        sum_wdata = init_sum(sweep_q);
        top_we    = (32'(sweep_q) < 32'(TOP_CHUNKS));
        top_waddr = sweep_q[AW_T-1:0];
        top_wdata = init_top(sweep_q);
        sweep_d   = sweep_q + AW_M'(1);
        if (sweep_q == AW_M'(MAP_WORDS - 1)) begin
          state_d = BBA_IDLE;
        end
      end

      // Take a request; top chunk 0 is being read meanwhile
      BBA_IDLE: begin
        top_raddr = '0;
        chunk_d   = '0;
        if (in_xfer) begin
          idx_d     = s_axis_tdata;
          granted_d = '0;
          status_d  = STATUS_DONE;
          if (!s_axis_tuser[0]) begin
            state_d = BBA_TOP;
          end else if (s_axis_tdata == '0) begin
            status_d = STATUS_ZERO;
            state_d  = BBA_RESP;
          end else if (32'(s_axis_tdata) >= 32'(NUM_BLOCKS)) begin
            state_d = BBA_RESP;
          end else begin
            state_d = BBA_DIV;
          end
        end
      end

      // Find a row with room, or advance to the next chunk
      BBA_TOP: begin
        top_word_d = top_rdata;
        row_d      = {chunk_q, ffz_pos};
        sum_raddr  = row_d[AW_S-1:0];
        if (ffz_found) begin
          state_d = BBA_SUM;
        end else if (chunk_q == AW_T'(TOP_CHUNKS - 1)) begin
          status_d = STATUS_FULL;
          state_d  = BBA_RESP;
        end else begin
          chunk_d   = chunk_q + AW_T'(1);
          top_raddr = chunk_d;
        end
      end

      // Find a map word with room
      BBA_SUM: begin
        sum_word_d = sum_rdata;
        word_d     = {row_q, ffz_pos};
        map_raddr  = word_d[AW_M-1:0];
        state_d    = BBA_MAP;
      end

      // Claim the bit and propagate fullness upwards
      BBA_MAP: begin
        map_we    = 1'b1;
        map_wdata = map_set;
        sum_we    = &map_set;
        top_we    = (&map_set) && (&sum_set);
        granted_d = grant_calc[IDX_W-1:0];
        state_d   = BBA_RESP;
      end

      // Split the index into word and bit
      BBA_DIV: begin
        word_d  = WW'(div_prod[PROD_W-1:DIV_SHIFT]);
        state_d = BBA_FRD;
      end

      // Read the word and both summary levels that cover it
      BBA_FRD: begin
        bit_d     = bit_calc[FIND_POS_W-1:0];
        map_raddr = word_q[AW_M-1:0];
        sum_raddr = free_row[AW_S-1:0];
        top_raddr = free_row[RW-1:SUM_SHIFT];
        state_d   = BBA_FWR;
      end

      // Release the bit; the word and its row are no longer full
      BBA_FWR: begin
        map_we    = 1'b1;
        map_waddr = word_q[AW_M-1:0];
        map_wdata = map_clr;
        sum_we    = 1'b1;
        sum_waddr = free_row[AW_S-1:0];
        sum_wdata = sum_rdata & ~(SUM_BITS'(1) << word_q[SUM_SHIFT-1:0]);
        top_we    = 1'b1;
        top_waddr = free_row[RW-1:SUM_SHIFT];
        top_wdata = top_rdata & ~(SUM_BITS'(1) << free_row[SUM_SHIFT-1:0]);
        state_d   = BBA_RESP;
      end

      // Hold the result until the transfer completes
      BBA_RESP: begin
        if (m_axis_tready) begin
          state_d = BBA_IDLE;
        end
      end

      default: begin
        state_d = BBA_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BBA_CLEAR;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    chunk_q    <= chunk_d;
    row_q      <= row_d;
    word_q     <= word_d;
    bit_q      <= bit_d;
    idx_q      <= idx_d;
    top_word_q <= top_word_d;
    sum_word_q <= sum_word_d;
    granted_q  <= granted_d;
    status_q   <= status_d;
  end

  assign s_axis_tready = (state_q == BBA_IDLE);
  assign m_axis_tvalid = (state_q == BBA_RESP);
  assign m_axis_tdata  = granted_q;
  assign m_axis_tuser  = status_q;

endmodule

`default_nettype wire

/* hw/rtl/bba_checker.sv */
// Port-level checks for the block allocator, bound to the top level.
// Depends on bba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bba_checker import bba_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [IDX_W-1:0]    s_axis_tdata,
  input wire logic [0:0]          s_axis_tuser,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [IDX_W-1:0]    m_axis_tdata,
  input wire logic [STATUS_W-1:0] m_axis_tuser
);

  // One request at a time: no request taken while a result waits
  `BBA_ASSERT(a_no_take_while_result, m_axis_tvalid |-> !s_axis_tready, "request taken with result pending")

  // A taken request closes the input side on the next cycle
  `BBA_ASSERT(a_busy_after_take, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "ready after taking a request")

  // Only defined status codes appear
  `BBA_ASSERT(a_status_code, m_axis_tvalid |-> (m_axis_tuser == STATUS_DONE || m_axis_tuser == STATUS_FULL || m_axis_tuser == STATUS_ZERO), "undefined status code")

  // A full map and a free of block zero never carry a block index
  `BBA_ASSERT(a_index_zero, (m_axis_tvalid && m_axis_tuser != STATUS_DONE) |-> (m_axis_tdata == '0), "index with non-done status")

  // A stalled result holds
  `BBA_ASSERT(a_result_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* tb/tb_bitmap_block_allocator_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_block_allocator_top: stream stimulus with random
// stalls, an in-bench first-fit predictor and a result checker. Depends on bba_pkg.

module tb_bitmap_block_allocator_top;
  import bba_pkg::*;

  localparam int N_BLOCKS       = NUM_BLOCKS_DEF;
  localparam int N_RESERVED     = RESERVED_BLOCKS_DEF;
  localparam int STALL_LIMIT    = 20000;
  localparam int RANDOM_PER_RUN = 400;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef struct {
    action_e          action;
    logic [IDX_W-1:0] index;
    bit               pick_live;  // free a block granted earlier, chosen at load time
  } request_t;

  typedef struct {
    logic [IDX_W-1:0] granted;
    status_e          status;
  } grant_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IDX_W-1:0]    s_axis_tdata  = '0;   // [15:0] block_index
  logic [0:0]          s_axis_tuser  = '0;   // [0] action
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [IDX_W-1:0]    m_axis_tdata;         // [15:0] granted_index
  logic [STATUS_W-1:0] m_axis_tuser;         // [1:0] status

  // Predicted allocator state
  bit               block_used [N_BLOCKS];
  int unsigned      lowest_maybe_free;
  logic [IDX_W-1:0] live_blocks[$];

  request_t request_queue[$];
  grant_t   awaited_grants[$];
  int       mismatch_count = 0;
  int       send_idle_pct  = 0;
  int       recv_idle_pct  = 0;
  int       stall_cycles   = 0;

  bitmap_block_allocator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one accepted request to the predicted map and return its result
  function automatic grant_t allocate_or_release(input logic act, input logic [IDX_W-1:0] idx);
    grant_t      res;
    int unsigned b;
    res.granted = '0;
    res.status  = STATUS_DONE;
    if (act == ACT_ALLOC) begin
      // Everything below the hint is known to be in use
      b = lowest_maybe_free;
      while (b < N_BLOCKS && block_used[b]) b++;
      lowest_maybe_free = b;
      if (b >= N_BLOCKS) begin
        res.status = STATUS_FULL;
      end else begin
        block_used[b] = 1'b1;
        res.granted = b[IDX_W-1:0];
        live_blocks.push_back(b[IDX_W-1:0]);
      end
    end else if (idx == '0) begin
      res.status = STATUS_ZERO;
    end else if (int'(idx) < N_BLOCKS) begin
      block_used[idx] = 1'b0;
      if (idx < lowest_maybe_free) lowest_maybe_free = idx;
    end
    return res;
  endfunction

  task automatic queue_request(input action_e act, input logic [IDX_W-1:0] idx,
                               input bit live = 1'b0);
    request_t req;
    req.action    = act;
    req.index     = idx;
    req.pick_live = live;
    request_queue.push_back(req);
  endtask

  // Mostly allocate/free churn on granted blocks, the rest odd frees
  task automatic queue_random_requests(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 52) begin
        queue_request(ACT_ALLOC, IDX_W'($urandom));
      end else if (r < 84) begin
        queue_request(ACT_FREE, '0, 1'b1);
      end else begin
        case ($urandom_range(3))
          0:       queue_request(ACT_FREE, '0);
          1:       queue_request(ACT_FREE, IDX_W'($urandom_range(1, N_RESERVED - 1)));
          2:       queue_request(ACT_FREE, IDX_W'($urandom));
          default: queue_request(ACT_FREE, IDX_W'(16'hFFFF - $urandom_range(3)));
        endcase
      end
    end
  endtask

  // Hold further stimulus until every awaited result has come back
  task automatic wait_all_granted();
    while (request_queue.size() != 0 || s_axis_tvalid || awaited_grants.size() != 0)
      @(negedge clk_i);
  endtask

  // Request driver: predict on each transfer, then load the next request
  always @(posedge clk_i) begin : drive_requests
    request_t         req;
    logic [IDX_W-1:0] idx;
    action_e          act;
    int               k;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        awaited_grants.push_back(allocate_or_release(s_axis_tuser[0], s_axis_tdata));
      end
      if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = request_queue.pop_front();
        act = req.action;
        idx = req.index;
        if (req.pick_live) begin
          if (live_blocks.size() != 0) begin
            k   = $urandom_range(live_blocks.size() - 1);
            idx = live_blocks[k];
            live_blocks.delete(k);
          end else begin
            act = ACT_ALLOC;
          end
        end
        s_axis_tuser  <= act;
        s_axis_tdata  <= idx;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: compare each transfer with the oldest awaited result
  always @(posedge clk_i) begin : check_grants
    grant_t exp_g;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_grants.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result with nothing awaited: index %0d status %0d",
                   m_axis_tdata, m_axis_tuser);
      end else begin
        exp_g = awaited_grants.pop_front();
        if (m_axis_tdata !== exp_g.granted || m_axis_tuser !== exp_g.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: granted_index exp %0d got %0d, status exp %0d got %0d",
                     exp_g.granted, m_axis_tdata, exp_g.status, m_axis_tuser);
        end
      end
    end
  end

  // Watchdog: count cycles with work pending but no transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (request_queue.size() == 0 && !s_axis_tvalid && awaited_grants.size() == 0)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < N_BLOCKS; i++) block_used[i] = (i < N_RESERVED);
    lowest_maybe_free = 0;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: first grants, free of block zero, reserved and already-clear frees
    send_idle_pct = 16;
    recv_idle_pct = 61;
    queue_request(ACT_ALLOC, 16'h0000);
    queue_request(ACT_ALLOC, 16'hFFFF);
    queue_request(ACT_FREE,  16'h0000);
    queue_request(ACT_FREE,  16'hFFFF);
    queue_request(ACT_FREE,  IDX_W'(N_RESERVED));
    queue_request(ACT_ALLOC, 16'h0000);
    queue_request(ACT_FREE,  16'h0001);
    queue_request(ACT_ALLOC, 16'h0000);
    queue_request(ACT_FREE,  IDX_W'(N_RESERVED + 1));
    queue_request(ACT_FREE,  IDX_W'(N_RESERVED + 1));
    queue_request(ACT_FREE,  IDX_W'(N_RESERVED - 1));
    queue_request(ACT_FREE,  IDX_W'(N_RESERVED - 2));
    queue_request(ACT_ALLOC, 16'h0000);
    queue_request(ACT_ALLOC, 16'h0000);
    queue_request(ACT_ALLOC, 16'h0000);
    queue_request(ACT_FREE,  16'h5555);
    queue_request(ACT_FREE,  16'hAAAA);
    queue_request(ACT_ALLOC, 16'h5555);
    queue_request(ACT_FREE,  16'h003F);
    queue_request(ACT_ALLOC, 16'hAAAA);
    queue_request(ACT_FREE,  16'h8000);
    queue_request(ACT_FREE,  16'h0000);
    wait_all_granted();

    // Random churn under three back-pressure profiles
    queue_random_requests(RANDOM_PER_RUN);
    wait_all_granted();
    send_idle_pct = 61;
    recv_idle_pct = 16;
    queue_random_requests(RANDOM_PER_RUN);
    wait_all_granted();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_requests(RANDOM_PER_RUN);
    wait_all_granted();

    // Probe the top block, frees of far blocks and further grants
    queue_request(ACT_ALLOC, 16'h0000);
    queue_request(ACT_ALLOC, 16'hFFFF);
    queue_request(ACT_FREE,  16'hFFFF);
    queue_request(ACT_ALLOC, 16'h0000);
    queue_request(ACT_ALLOC, 16'h0000);
    queue_request(ACT_FREE,  16'h0000);
    queue_request(ACT_FREE,  16'd40000);
    queue_request(ACT_FREE,  16'd12345);
    queue_request(ACT_ALLOC, 16'h0000);
    queue_request(ACT_ALLOC, 16'h0000);
    queue_request(ACT_ALLOC, 16'h0000);
    wait_all_granted();

    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && awaited_grants.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
